/* sv/pfba_pkg.sv */
// Package for the physical frame bitmap allocator.
// Holds the request/response payload types, status and opcode constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pfba_pkg;

   localparam int unsigned FRAME_W    = 12;
   localparam int unsigned STATUS_W   = 3;
   // frames addressable through the 12-bit frame field
   localparam int unsigned FRAME_SPAN = 4096;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MAPPED    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FREED     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTHING   = 3'd4;

   typedef struct packed {
      logic               op;
      logic [FRAME_W-1:0] entry_frame;
      logic               kernel_page;
      logic               writeable;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FRAME_W-1:0]  new_frame;
      logic                present_bit;
      logic                rw_bit;
      logic                user_bit;
   } rsp_type;

endpackage

`default_nettype wire

/* sv/pfba_req_if.sv */
// Request channel of the frame allocator: valid/ready handshake with a request payload.
// Depends on pfba_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pfba_req_if;
   logic             valid;
   logic             ready;
   pfba_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/pfba_rsp_if.sv */
// Response channel of the frame allocator: valid/ready handshake with a response payload.
// Depends on pfba_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pfba_rsp_if;
   logic             valid;
   logic             ready;
   pfba_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/physical_frame_bitmap_allocator_core.sv */
// Steps to rsp valid: allocate S_AREAD, S_ACHK (both again per full word skipped), S_AMUL,
// S_RESP; out of frames S_AREAD, S_RESP; free S_FDIV, S_FREAD, S_FMOD, S_RESP; others S_RESP.
// Throughput: one transaction at a time, set by the read-modify-write of the bitmap RAM; ready
// returns in the cycle rsp valid rises, and a held response stalls the next one before output.
// Reset: synchronous; the map reads as all free at once (words at or above the fill mark read
// as zero), the first-fit pointer returns to word 0 and the response register empties.
`timescale 1ns / 1ps
`default_nettype none

module physical_frame_bitmap_allocator_core #(
   parameter int unsigned NUM_FRAMES    = 4096,
   parameter int unsigned BITS_PER_WORD = 32
) (
   input  wire          clock,
   input  wire          reset,
   pfba_req_if.sink     req_ch,
   pfba_rsp_if.source   rsp_ch
);

   localparam int unsigned FW         = pfba_pkg::FRAME_W;
   localparam int unsigned SCAN_LIMIT = (NUM_FRAMES < pfba_pkg::FRAME_SPAN) ?
                                        NUM_FRAMES : pfba_pkg::FRAME_SPAN;
   localparam int unsigned SCAN_WORDS = (SCAN_LIMIT + BITS_PER_WORD - 1) / BITS_PER_WORD;
   localparam int unsigned LAST_BITS  = SCAN_LIMIT - (SCAN_WORDS - 1) * BITS_PER_WORD;
   localparam int unsigned AW         = (SCAN_WORDS > 1) ? $clog2(SCAN_WORDS) : 1;
   localparam int unsigned CW         = $clog2(SCAN_WORDS + 1);
   localparam int unsigned BW         = $clog2(BITS_PER_WORD);
   localparam int unsigned QSHIFT     = 24;
   localparam int unsigned RECIP      = ((1 << QSHIFT) + BITS_PER_WORD - 1) / BITS_PER_WORD;
   localparam int unsigned PW         = QSHIFT + FW;

   localparam logic [BITS_PER_WORD-1:0] LAST_FILL =
      {BITS_PER_WORD{1'b1}} >> (BITS_PER_WORD - LAST_BITS);
   localparam logic [BITS_PER_WORD-1:0] PAD_MASK = ~LAST_FILL;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_AREAD = 3'd1;
   localparam logic [2:0] S_ACHK  = 3'd2;
   localparam logic [2:0] S_AMUL  = 3'd3;
   localparam logic [2:0] S_FDIV  = 3'd4;
   localparam logic [2:0] S_FREAD = 3'd5;
   localparam logic [2:0] S_FMOD  = 3'd6;
   localparam logic [2:0] S_RESP  = 3'd7;

   // bitmap RAM
   logic [BITS_PER_WORD-1:0] map_mem [SCAN_WORDS];
   logic [BITS_PER_WORD-1:0] rdata_ff;
   logic                     mem_re;
   logic                     mem_we;
   logic [AW-1:0]            mem_raddr;
   logic [AW-1:0]            mem_waddr;
   logic [BITS_PER_WORD-1:0] mem_wdata;

   logic [2:0]        state_ff, state_in;
   pfba_pkg::req_type req_ff, req_in;
   logic [CW-1:0]     hint_ff, hint_in;
   logic [CW-1:0]     hwm_ff, hwm_in;
   logic [CW-1:0]     word_ff, word_in;
   logic [BW-1:0]     bit_ff, bit_in;
   pfba_pkg::rsp_type res_ff, res_in;
   pfba_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic                     req_fire;
   logic [PW-1:0]            quot_prod;
   logic [FW-1:0]            rem_full;
   logic [BITS_PER_WORD-1:0] cur_word;
   logic [BITS_PER_WORD-1:0] masked_word;
   logic [BW-1:0]            zero_idx;
   logic [FW-1:0]            grant_frame;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_ff;

   assign quot_prod   = PW'(req_ff.entry_frame) * PW'(RECIP);
   assign rem_full    = req_ff.entry_frame - FW'(FW'(word_ff) * FW'(BITS_PER_WORD));
   assign grant_frame = FW'(FW'(hint_ff) * FW'(BITS_PER_WORD)) + FW'(bit_ff);

   // words at or above the fill mark were never written and read as free
   always_comb begin
      cur_word    = (state_ff == S_FMOD ? word_ff : hint_ff) < hwm_ff ? rdata_ff : '0;
      masked_word = (hint_ff == CW'(SCAN_WORDS - 1)) ? (cur_word | PAD_MASK) : cur_word;
   end

   // lowest clear bit of the word under test
   always_comb begin
      zero_idx = '0;
      for (int i = BITS_PER_WORD - 1; i >= 0; i--) begin
         if (!masked_word[i]) begin
            zero_idx = BW'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      hint_in      = hint_ff;
      hwm_in       = hwm_ff;
      word_in      = word_ff;
      bit_in       = bit_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      mem_re       = 1'b0;
      mem_we       = 1'b0;
      mem_raddr    = hint_ff[AW-1:0];
      mem_waddr    = hint_ff[AW-1:0];
      mem_wdata    = masked_word;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               req_in = req_ch.data;
               res_in = '0;
               if (req_ch.data.op == pfba_pkg::OP_ALLOC) begin
                  if (req_ch.data.entry_frame != '0) begin
                     res_in.status    = pfba_pkg::ST_MAPPED;
                     res_in.new_frame = req_ch.data.entry_frame;
                     state_in         = S_RESP;
                  end else begin
                     state_in = S_AREAD;
                  end
               end else begin
                  if (req_ch.data.entry_frame == '0) begin
                     res_in.status = pfba_pkg::ST_NOTHING;
                     state_in      = S_RESP;
                  end else if ((FW+1)'(req_ch.data.entry_frame) >= (FW+1)'(SCAN_LIMIT)) begin
                     // frame outside the map: report freed, touch nothing
                     res_in.status = pfba_pkg::ST_FREED;
                     state_in      = S_RESP;
                  end else begin
                     res_in.status = pfba_pkg::ST_FREED;
                     state_in      = S_FDIV;
                  end
               end
            end
         end
         S_AREAD: begin
            if (hint_ff == CW'(SCAN_WORDS)) begin
               res_in.status = pfba_pkg::ST_EXHAUSTED;
               state_in      = S_RESP;
            end else begin
               mem_re   = 1'b1;
               state_in = S_ACHK;
            end
         end
         S_ACHK: begin
            if (&masked_word) begin
               // word full: advance the first-fit pointer
               hint_in  = hint_ff + CW'(1);
               state_in = S_AREAD;
            end else begin
               mem_we    = 1'b1;
               mem_wdata = cur_word | (BITS_PER_WORD'(1) << zero_idx);
               bit_in    = zero_idx;
               if (hint_ff == hwm_ff) begin
                  hwm_in = hwm_ff + CW'(1);
               end
               state_in = S_AMUL;
            end
         end
         S_AMUL: begin
            res_in.status      = pfba_pkg::ST_ALLOCATED;
            res_in.new_frame   = grant_frame;
            res_in.present_bit = 1'b1;
            res_in.rw_bit      = req_ff.writeable;
            res_in.user_bit    = ~req_ff.kernel_page;
            state_in           = S_RESP;
         end
         S_FDIV: begin
            word_in  = quot_prod[QSHIFT +: CW];
            state_in = S_FREAD;
         end
         S_FREAD: begin
            bit_in    = rem_full[BW-1:0];
            mem_re    = 1'b1;
            mem_raddr = word_ff[AW-1:0];
            state_in  = S_FMOD;
         end
         S_FMOD: begin
            if (word_ff < hwm_ff) begin
               mem_we    = 1'b1;
               mem_waddr = word_ff[AW-1:0];
               mem_wdata = cur_word & ~(BITS_PER_WORD'(1) << bit_ff);
            end
            if (word_ff < hint_ff) begin
               hint_in = word_ff;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= map_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hint_ff      <= '0;
         hwm_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hint_ff      <= hint_in;
         hwm_ff       <= hwm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff  <= req_in;
      word_ff <= word_in;
      bit_ff  <= bit_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

`ifndef SYNTH
   a_hint_below_fill: assert property (@(posedge clock) disable iff (reset)
      hint_ff <= hwm_ff)
      else $error("first-fit pointer above fill mark");

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      hwm_ff <= CW'(SCAN_WORDS))
      else $error("fill mark beyond map");

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("map read and write in the same cycle");

   a_alloc_present: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == pfba_pkg::ST_ALLOCATED) |-> rsp_ff.present_bit)
      else $error("allocation without present bit");
`endif

endmodule

`default_nettype wire

/* verif/tb_physical_frame_bitmap_allocator_core.sv */
// Self-checking testbench for physical_frame_bitmap_allocator_core: directed table, then random
// allocate/free traffic, checked against pinned table results or a bitmap predictor.
// Depends on pfba_pkg, pfba_req_if, pfba_rsp_if and the core.
`timescale 1ns / 1ps

module tb_physical_frame_bitmap_allocator_core;

   // first-fit pointer may step over every one of the 128 full map words
   localparam int unsigned DRAIN_CYCLES = 300;
   localparam int unsigned RANDOM_ITEMS = 930;
   localparam int unsigned IDLE_MAX     = 16;
   localparam int unsigned FW           = pfba_pkg::FRAME_W;
   localparam int unsigned SPAN         = pfba_pkg::FRAME_SPAN;

   typedef struct {
      pfba_pkg::req_type req;
      bit                pinned;
      pfba_pkg::rsp_type want;
   } table_row_type;

   logic clock = 1'b0;
   logic reset;

   pfba_req_if req_if();
   pfba_rsp_if rsp_if();

   physical_frame_bitmap_allocator_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state: one used bit per frame
   bit [SPAN-1:0]     frame_used;
   pfba_pkg::rsp_type outcome_q[$];
   logic [FW-1:0]     held_frames[$];
   table_row_type     stim_table[$];
   int unsigned       mismatch_count = 0;
   int unsigned       n_granted = 0, n_mapped = 0, n_exhausted = 0;
   int unsigned       n_freed = 0, n_nothing = 0;

   function automatic pfba_pkg::rsp_type frame_outcome(input pfba_pkg::req_type r);
      pfba_pkg::rsp_type o;
      int unsigned       f;
      o = '0;
      if (r.op == pfba_pkg::OP_ALLOC) begin
         if (r.entry_frame != '0) begin
            o.status    = pfba_pkg::ST_MAPPED;
            o.new_frame = r.entry_frame;
            n_mapped++;
         end else begin
            f = 0;
            while (f < SPAN && frame_used[f]) f++;
            if (f < SPAN) begin
               frame_used[f] = 1'b1;
               o.status      = pfba_pkg::ST_ALLOCATED;
               o.new_frame   = FW'(f);
               o.present_bit = 1'b1;
               o.rw_bit      = r.writeable;
               o.user_bit    = ~r.kernel_page;
               n_granted++;
            end else begin
               o.status = pfba_pkg::ST_EXHAUSTED;
               n_exhausted++;
            end
         end
      end else begin
         if (r.entry_frame != '0) begin
            frame_used[r.entry_frame] = 1'b0;
            o.status = pfba_pkg::ST_FREED;
            n_freed++;
         end else begin
            o.status = pfba_pkg::ST_NOTHING;
            n_nothing++;
         end
      end
      return o;
   endfunction

   function automatic pfba_pkg::req_type make_req(input logic op, input int unsigned entry,
                                                  input logic kern, input logic wr);
      pfba_pkg::req_type r;
      r.op          = op;
      r.entry_frame = FW'(entry);
      r.kernel_page = kern;
      r.writeable   = wr;
      return r;
   endfunction

   function automatic pfba_pkg::rsp_type make_rsp(input logic [pfba_pkg::STATUS_W-1:0] st,
                                                  input int unsigned frame, input logic p,
                                                  input logic rw, input logic u);
      pfba_pkg::rsp_type o;
      o.status      = st;
      o.new_frame   = FW'(frame);
      o.present_bit = p;
      o.rw_bit      = rw;
      o.user_bit    = u;
      return o;
   endfunction

   function automatic void add_row(input pfba_pkg::req_type r, input bit pinned,
                                   input pfba_pkg::rsp_type want);
      table_row_type row;
      row.req    = r;
      row.pinned = pinned;
      row.want   = want;
      stim_table.push_back(row);
   endfunction

   function automatic int unsigned draw_idle();
      return $urandom_range(0, IDLE_MAX);
   endfunction

   task automatic issue_request(input pfba_pkg::req_type r, input bit pinned,
                                input pfba_pkg::rsp_type want);
      int unsigned       gap;
      pfba_pkg::rsp_type predicted;
      gap = draw_idle();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= r;
      do @(posedge clock); while (!req_if.ready);
      predicted = frame_outcome(r);
      if (predicted.status == pfba_pkg::ST_ALLOCATED) held_frames.push_back(predicted.new_frame);
      outcome_q.push_back(pinned ? want : predicted);
   endtask

   task automatic issue_random();
      int unsigned pick, idx, entry;
      logic        op;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         op = pfba_pkg::OP_ALLOC;
         entry = 0;
      end else if (pick < 65) begin
         op = pfba_pkg::OP_ALLOC;
         entry = $urandom_range(1, SPAN - 1);
      end else if (pick < 85) begin
         op = pfba_pkg::OP_FREE;
         if (held_frames.size() > 0) begin
            idx = $urandom_range(0, held_frames.size() - 1);
            entry = held_frames[idx];
            held_frames.delete(idx);
         end else begin
            entry = $urandom_range(1, SPAN - 1);
         end
      end else if (pick < 93) begin
         op = pfba_pkg::OP_FREE;
         entry = $urandom_range(0, SPAN - 1);
      end else begin
         op = pfba_pkg::OP_FREE;
         entry = 0;
      end
      issue_request(make_req(op, entry, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))),
                    1'b0, '0);
   endtask

   // response side: random backpressure, compare against the oldest expectation
   int unsigned rsp_stall;
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall = 0;
      end else if (rsp_if.valid && rsp_if.ready) begin
         if (outcome_q.size() == 0) begin
            $error("response transaction with no request outstanding");
            mismatch_count++;
         end else begin
            pfba_pkg::rsp_type e;
            e = outcome_q.pop_front();
            if (rsp_if.data.status !== e.status) begin
               $error("status: expected %0d, actual %0d", e.status, rsp_if.data.status);
               mismatch_count++;
            end
            if (rsp_if.data.new_frame !== e.new_frame) begin
               $error("new_frame: expected %0d, actual %0d", e.new_frame, rsp_if.data.new_frame);
               mismatch_count++;
            end
            if (rsp_if.data.present_bit !== e.present_bit) begin
               $error("present_bit: expected %0d, actual %0d", e.present_bit,
                      rsp_if.data.present_bit);
               mismatch_count++;
            end
            if (rsp_if.data.rw_bit !== e.rw_bit) begin
               $error("rw_bit: expected %0d, actual %0d", e.rw_bit, rsp_if.data.rw_bit);
               mismatch_count++;
            end
            if (rsp_if.data.user_bit !== e.user_bit) begin
               $error("user_bit: expected %0d, actual %0d", e.user_bit, rsp_if.data.user_bit);
               mismatch_count++;
            end
         end
         rsp_stall = draw_idle();
         rsp_if.ready <= (rsp_stall == 0);
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_if.ready <= (rsp_stall == 0);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   initial begin
      #20_000_000;
      $display("tb_physical_frame_bitmap_allocator_core NOT OK");
      $finish;
   end

   initial begin
      frame_used = '0;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.data  <= '0;

      // directed: extremes, both operations, frame zero, free of an unused frame, already mapped
      add_row(make_req(pfba_pkg::OP_ALLOC, 0, 1'b0, 1'b1), 1'b1,
              make_rsp(pfba_pkg::ST_ALLOCATED, 0, 1'b1, 1'b1, 1'b1));
      add_row(make_req(pfba_pkg::OP_ALLOC, 0, 1'b1, 1'b0), 1'b1,
              make_rsp(pfba_pkg::ST_ALLOCATED, 1, 1'b1, 1'b0, 1'b0));
      add_row(make_req(pfba_pkg::OP_ALLOC, 4095, 1'b0, 1'b1), 1'b1,
              make_rsp(pfba_pkg::ST_MAPPED, 4095, 1'b0, 1'b0, 1'b0));
      add_row(make_req(pfba_pkg::OP_ALLOC, 1, 1'b1, 1'b1), 1'b1,
              make_rsp(pfba_pkg::ST_MAPPED, 1, 1'b0, 1'b0, 1'b0));
      add_row(make_req(pfba_pkg::OP_FREE, 0, 1'b0, 1'b1), 1'b1,
              make_rsp(pfba_pkg::ST_NOTHING, 0, 1'b0, 1'b0, 1'b0));
      add_row(make_req(pfba_pkg::OP_FREE, 4095, 1'b1, 1'b1), 1'b1,
              make_rsp(pfba_pkg::ST_FREED, 0, 1'b0, 1'b0, 1'b0));
      add_row(make_req(pfba_pkg::OP_FREE, 1, 1'b0, 1'b0), 1'b1,
              make_rsp(pfba_pkg::ST_FREED, 0, 1'b0, 1'b0, 1'b0));
      add_row(make_req(pfba_pkg::OP_ALLOC, 0, 1'b0, 1'b0), 1'b1,
              make_rsp(pfba_pkg::ST_ALLOCATED, 1, 1'b1, 1'b0, 1'b1));
      add_row(make_req(pfba_pkg::OP_ALLOC, 0, 1'b1, 1'b1), 1'b1,
              make_rsp(pfba_pkg::ST_ALLOCATED, 2, 1'b1, 1'b1, 1'b0));
      add_row(make_req(pfba_pkg::OP_ALLOC, 0, 1'b0, 1'b1), 1'b0, '0);
      add_row(make_req(pfba_pkg::OP_FREE, 2048, 1'b0, 1'b0), 1'b1,
              make_rsp(pfba_pkg::ST_FREED, 0, 1'b0, 1'b0, 1'b0));
      add_row(make_req(pfba_pkg::OP_ALLOC, 2048, 1'b0, 1'b0), 1'b1,
              make_rsp(pfba_pkg::ST_MAPPED, 2048, 1'b0, 1'b0, 1'b0));
      add_row(make_req(pfba_pkg::OP_ALLOC, 'hAAA, 1'b1, 1'b0), 1'b1,
              make_rsp(pfba_pkg::ST_MAPPED, 'hAAA, 1'b0, 1'b0, 1'b0));
      add_row(make_req(pfba_pkg::OP_ALLOC, 'h555, 1'b0, 1'b1), 1'b1,
              make_rsp(pfba_pkg::ST_MAPPED, 'h555, 1'b0, 1'b0, 1'b0));
      add_row(make_req(pfba_pkg::OP_FREE, 'hAAA, 1'b1, 1'b1), 1'b1,
              make_rsp(pfba_pkg::ST_FREED, 0, 1'b0, 1'b0, 1'b0));
      add_row(make_req(pfba_pkg::OP_FREE, 'h555, 1'b0, 1'b0), 1'b1,
              make_rsp(pfba_pkg::ST_FREED, 0, 1'b0, 1'b0, 1'b0));
      add_row(make_req(pfba_pkg::OP_FREE, 2, 1'b1, 1'b0), 1'b1,
              make_rsp(pfba_pkg::ST_FREED, 0, 1'b0, 1'b0, 1'b0));
      add_row(make_req(pfba_pkg::OP_ALLOC, 0, 1'b1, 1'b0), 1'b0, '0);
      add_row(make_req(pfba_pkg::OP_FREE, 0, 1'b1, 1'b0), 1'b1,
              make_rsp(pfba_pkg::ST_NOTHING, 0, 1'b0, 1'b0, 1'b0));
      add_row(make_req(pfba_pkg::OP_ALLOC, 0, 1'b1, 1'b1), 1'b0, '0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_table[i])
         issue_request(stim_table[i].req, stim_table[i].pinned, stim_table[i].want);

      repeat (RANDOM_ITEMS) issue_random();

      req_if.valid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (outcome_q.size() != 0) begin
         $error("%0d responses never arrived", outcome_q.size());
         mismatch_count++;
      end
      $display("Covered %0d grants, %0d already mapped, %0d out of frames,",
               n_granted, n_mapped, n_exhausted);
      $display("%0d frees and %0d empty frees under random stalls on both sides.",
               n_freed, n_nothing);
      if (mismatch_count == 0) begin
         $display("tb_physical_frame_bitmap_allocator_core OK");
      end else begin
         $display("tb_physical_frame_bitmap_allocator_core NOT OK");
      end
      $finish;
   end

endmodule
